>>> hw/rtl/hvt_pkg.sv
// Shared types, constants and arithmetic helpers for the homogeneous vertex transform.
package hvt_pkg;

    // Coefficient and coordinate word (Q16.16)
    localparam int WORD_W   = 32;
    // Exact sum of three Q32.32 products
    localparam int ACC_W    = 66;
    // Row sum after floor to Q16.16, plus the translation column
    localparam int SUM_W    = 51;
    // Quotient bits, one per divide stage
    localparam int Q_W      = 32;
    localparam int FRAC_W   = 16;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 4;
    localparam int CFG_W    = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Mode codes
    localparam logic [1:0] FUNC_DIV_W    = 2'd0;
    localparam logic [1:0] FUNC_DIV_ABS  = 2'd1;
    localparam logic [1:0] FUNC_NO_DIV   = 2'd2;
    // Spare code, handled as no divide
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    // Register reset values: identity matrix
    localparam logic [NUM_REGS-1:0][CFG_W-1:0] CFG_RESET = {
        64'h0001_0000_0000_0000, 64'h0,
        64'h0000_0000_0001_0000, 64'h0,
        64'h0, 64'h0001_0000_0000_0000,
        64'h0, 64'h0000_0000_0001_0000
    };

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [3:0][3:0][WORD_W-1:0] coef_mat_t;

    // One classified item handed from the front to the back
    typedef struct packed {
        sum_t       sx;
        sum_t       sy;
        sum_t       sz;
        sum_t       sw;
        logic       div;
        logic       zero_w;
        logic [2:0] neg;
    } job_t;

    typedef struct packed {
        logic [WORD_W-1:0] val;
        logic              sat;
    } clamp_t;

    // Per-item bookkeeping riding along the divide pipeline
    typedef struct packed {
        logic              div;
        logic              zero_w;
        logic [2:0]        neg;
        logic [WORD_W-1:0] w32;
        logic              w_sat;
        logic [WORD_W-1:0] px;
        logic [WORD_W-1:0] py;
        logic [WORD_W-1:0] pz;
        logic              p_sat;
    } meta_t;

    // Partial remainder and shared dividend / quotient word
    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [Q_W-1:0]   rq;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]      lane;
        logic [SUM_W-1:0] d;
        logic [2:0]       ovf;
        meta_t            meta;
    } dstage_t;

    // Clamp a full-width sum to the signed 32-bit range
    function automatic clamp_t clamp32(sum_t v);
        clamp_t o;
        o.sat = !((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1]));
        if (o.sat)
            o.val = v[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        else
            o.val = v[WORD_W-1:0];
        return o;
    endfunction

    // One restoring division step
    function automatic lane_t div_step(lane_t l, logic [SUM_W-1:0] d);
        logic [SUM_W:0] t;
        logic [SUM_W:0] diff;
        lane_t          o;
        t    = {l.r, l.rq[Q_W-1]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            o.r  = diff[SUM_W-1:0];
            o.rq = {l.rq[Q_W-2:0], 1'b1};
        end
        else
        begin
            o.r  = t[SUM_W-1:0];
            o.rq = {l.rq[Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> hw/rtl/hvt_front.sv
// Front end: accepts points, forms the four row sums and classifies each item.
module hvt_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                func,
    input  logic signed [31:0]        in_x,
    input  logic signed [31:0]        in_y,
    input  logic signed [31:0]        in_z,
    input  hvt_pkg::coef_mat_t        coef,
    input  logic                      q_full,
    output logic                      q_push,
    output hvt_pkg::job_t             q_job
);
    import hvt_pkg::*;

    logic                        s1_vld_reg;
    logic                        s2_vld_reg;
    logic signed [2*WORD_W-1:0]  prod_reg [4][3];
    logic [1:0]                  func1_reg;
    logic [1:0]                  func2_reg;
    sum_t                        sum_reg  [4];
    sum_t                        sum_next [4];
    logic                        en;

    assign en      = !s2_vld_reg || !q_full;
    assign s_ready = en;
    assign q_push  = s2_vld_reg && !q_full;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= s_valid;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Row sums: exact product sum, floor to Q16.16, add translation
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        for (int r = 0; r < 4; r++)
        begin
            acc = ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1]) + ACC_W'(prod_reg[r][2]);
            sum_next[r] = SUM_W'(acc >>> FRAC_W) + SUM_W'($signed(coef[r][3]));
        end
    end

    // Products, then sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                prod_reg[r][0] <= $signed(coef[r][0]) * in_x;
                prod_reg[r][1] <= $signed(coef[r][1]) * in_y;
                prod_reg[r][2] <= $signed(coef[r][2]) * in_z;
                sum_reg[r]     <= sum_next[r];
            end
            func1_reg <= func;
            func2_reg <= func1_reg;
        end
    end

    // Classification
    always_comb
    begin
        logic flip;
        flip          = (func2_reg == FUNC_DIV_W) && sum_reg[3][SUM_W-1];
        q_job.sx      = sum_reg[0];
        q_job.sy      = sum_reg[1];
        q_job.sz      = sum_reg[2];
        q_job.sw      = sum_reg[3];
        q_job.div     = func2_reg inside {FUNC_DIV_W, FUNC_DIV_ABS};
        q_job.zero_w  = (sum_reg[3] == '0);
        q_job.neg[0]  = sum_reg[0][SUM_W-1] ^ flip;
        q_job.neg[1]  = sum_reg[1][SUM_W-1] ^ flip;
        q_job.neg[2]  = sum_reg[2][SUM_W-1] ^ flip;
    end

endmodule

>>> hw/rtl/hvt_queue.sv
// Short queue decoupling the front end from the divide back end.
module hvt_queue #(
    parameter int DEPTH = hvt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hvt_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output hvt_pkg::job_t rd_job,
    output logic          empty
);
    import hvt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full   = (cnt_reg == CNT_W'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

>>> hw/rtl/hvt_back.sv
// Back end: magnitudes, pipelined 32-step divide, sign, clamp and output register.
module hvt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  hvt_pkg::job_t q_job,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [127:0]  m_data,
    output logic [1:0]    m_user
);
    import hvt_pkg::*;

    logic             en;
    logic             p_vld_reg;
    logic [SUM_W-1:0] pn_reg [3];
    logic [SUM_W-1:0] pd_reg;
    meta_t            pmeta_reg;
    logic             d_vld_reg [Q_W+1];
    dstage_t          d_reg     [Q_W+1];
    logic             o_vld_reg;
    logic [127:0]     o_data_reg;
    logic [1:0]       o_user_reg;
    dstage_t          d0_next;
    logic [127:0]     o_data_next;
    logic [1:0]       o_user_next;

    assign en      = !o_vld_reg || m_ready;
    assign q_pop   = en && !q_empty;
    assign m_valid = o_vld_reg;
    assign m_data  = o_data_reg;
    assign m_user  = o_user_reg;

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            for (int k = 0; k <= Q_W; k++)
                d_vld_reg[k] <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg    <= !q_empty;
            d_vld_reg[0] <= p_vld_reg;
            for (int k = 1; k <= Q_W; k++)
                d_vld_reg[k] <= d_vld_reg[k-1];
            o_vld_reg <= d_vld_reg[Q_W];
        end
    end

    // Divider set-up: high dividend bits form the first remainder
    always_comb
    begin
        logic [SUM_W-1:0] n;
        for (int j = 0; j < 3; j++)
        begin
            n = pn_reg[j];
            d0_next.lane[j].r  = SUM_W'(n[SUM_W-1:FRAC_W]);
            d0_next.lane[j].rq = {n[FRAC_W-1:0], {(Q_W-FRAC_W){1'b0}}};
            d0_next.ovf[j]     = (SUM_W'(n[SUM_W-1:FRAC_W]) >= pd_reg);
        end
        d0_next.d    = pd_reg;
        d0_next.meta = pmeta_reg;
    end

    // Final sign and clamp, and result selection by mode
    always_comb
    begin
        dstage_t          f;
        logic [Q_W:0]     mag;
        logic [Q_W-1:0]   q [3];
        logic [2:0]       qsat;
        f = d_reg[Q_W];
        for (int j = 0; j < 3; j++)
        begin
            mag = f.ovf[j] ? {1'b1, {Q_W{1'b0}}} : {1'b0, f.lane[j].rq};
            if (f.meta.neg[j])
            begin
                qsat[j] = (mag > {2'b01, {(Q_W-1){1'b0}}});
                q[j]    = qsat[j] ? {1'b1, {(Q_W-1){1'b0}}}
                                  : Q_W'({1'b1, {Q_W{1'b0}}} - mag);
            end
            else
            begin
                qsat[j] = (mag > {2'b00, {(Q_W-1){1'b1}}});
                q[j]    = qsat[j] ? {1'b0, {(Q_W-1){1'b1}}} : mag[Q_W-1:0];
            end
        end
        if (!f.meta.div)
        begin
            o_data_next = {f.meta.w32, f.meta.pz, f.meta.py, f.meta.px};
            o_user_next = {f.meta.w_sat | f.meta.p_sat, 1'b0};
        end
        else if (f.meta.zero_w)
        begin
            o_data_next = '0;
            o_user_next = 2'b01;
        end
        else
        begin
            o_data_next = {f.meta.w32, q[2], q[1], q[0]};
            o_user_next = {f.meta.w_sat | (|qsat), 1'b0};
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        clamp_t cx, cy, cz, cw;
        if (en)
        begin
            cx = clamp32(q_job.sx);
            cy = clamp32(q_job.sy);
            cz = clamp32(q_job.sz);
            cw = clamp32(q_job.sw);
            pn_reg[0] <= q_job.sx[SUM_W-1] ? SUM_W'(-q_job.sx) : SUM_W'(q_job.sx);
            pn_reg[1] <= q_job.sy[SUM_W-1] ? SUM_W'(-q_job.sy) : SUM_W'(q_job.sy);
            pn_reg[2] <= q_job.sz[SUM_W-1] ? SUM_W'(-q_job.sz) : SUM_W'(q_job.sz);
            pd_reg    <= q_job.sw[SUM_W-1] ? SUM_W'(-q_job.sw) : SUM_W'(q_job.sw);
            pmeta_reg.div    <= q_job.div;
            pmeta_reg.zero_w <= q_job.zero_w;
            pmeta_reg.neg    <= q_job.neg;
            pmeta_reg.w32    <= cw.val;
            pmeta_reg.w_sat  <= cw.sat;
            pmeta_reg.px     <= cx.val;
            pmeta_reg.py     <= cy.val;
            pmeta_reg.pz     <= cz.val;
            pmeta_reg.p_sat  <= cx.sat | cy.sat | cz.sat;
            d_reg[0] <= d0_next;
            for (int k = 1; k <= Q_W; k++)
            begin
                for (int j = 0; j < 3; j++)
                    d_reg[k].lane[j] <= div_step(d_reg[k-1].lane[j], d_reg[k-1].d);
                d_reg[k].d    <= d_reg[k-1].d;
                d_reg[k].ovf  <= d_reg[k-1].ovf;
                d_reg[k].meta <= d_reg[k-1].meta;
            end
            o_data_reg <= o_data_next;
            o_user_reg <= o_user_next;
        end
    end

    a_zero_w_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (o_vld_reg && o_user_reg[0]) |-> (o_data_reg == '0))
        else $error("zero w result carries non-zero data");
    a_zero_w_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        (o_vld_reg && o_user_reg[0]) |-> !o_user_reg[1])
        else $error("zero w result flagged as saturated");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(d_vld_reg[Q_W]) && $stable(p_vld_reg))
        else $error("divide pipeline moved during stall");

endmodule

>>> hw/rtl/homogeneous_vertex_transform_unit.sv
// Top level of the homogeneous vertex transform: config registers, front, queue and back.
// Throughput: one request per cycle unless m_tready holds the result side;
// the 32-stage restoring divider is fully pipelined.
// Row sums use twelve 32x32 multipliers in one stage, then one adder stage.
// Reset clears all valid state and loads the identity matrix into the config registers.
// Config writes are taken every cycle (cfg_ready is always high).
module homogeneous_vertex_transform_unit #(
    parameter int QUEUE_DEPTH = hvt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [95:0]                s_tdata,   // in_x, in_y, in_z
    input  logic [1:0]                 s_tuser,   // func
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [127:0]               m_tdata,   // out_x, out_y, out_z, out_w
    output logic [1:0]                 m_tuser,   // zero_w, saturated
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hvt_pkg::IDX_W-1:0]  cfg_index,
    input  logic [hvt_pkg::CFG_W-1:0]  cfg_data
);
    import hvt_pkg::*;

    logic [CFG_W-1:0] cfg_reg [NUM_REGS];
    coef_mat_t        coef;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    job_t             wr_job;
    job_t             rd_job;

    assign cfg_ready = 1'b1;

    // Matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= CFG_RESET[i];
        end
        else if (cfg_valid && (cfg_index < IDX_W'(NUM_REGS)))
        begin
            cfg_reg[cfg_index[IDX_W-2:0]] <= cfg_data;
        end
    end

    // Unpack coefficients: two per register
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            coef[r][0] = cfg_reg[2*r][WORD_W-1:0];
            coef[r][1] = cfg_reg[2*r][CFG_W-1:WORD_W];
            coef[r][2] = cfg_reg[2*r+1][WORD_W-1:0];
            coef[r][3] = cfg_reg[2*r+1][CFG_W-1:WORD_W];
        end
    end

    hvt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .func    (s_tuser),
        .in_x    ($signed(s_tdata[31:0])),
        .in_y    ($signed(s_tdata[63:32])),
        .in_z    ($signed(s_tdata[95:64])),
        .coef    (coef),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (wr_job)
    );

    hvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_job (wr_job),
        .full   (q_full),
        .pop    (q_pop),
        .rd_job (rd_job),
        .empty  (q_empty)
    );

    hvt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (rd_job),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata),
        .m_user  (m_tuser)
    );

endmodule

>>> tb/sv/homogeneous_vertex_transform_unit_test.sv
// Testbench for the homogeneous vertex transform: matrix phases, directed and random vertices.
`timescale 1ns / 1ps

module homogeneous_vertex_transform_unit_test;
    import hvt_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 45;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        zero_w;
        logic        sat;
    } vertex_t;

    // Scoreboard: holds the matrix copy and the queue of expected vertices
    class vertex_scoreboard;
        logic [CFG_W-1:0] mat_regs [NUM_REGS];
        vertex_t          pending [$];
        int               noted;
        int               checked;

        function void load_reset();
            for (int i = 0; i < NUM_REGS; i++)
                mat_regs[i] = CFG_RESET[i];
        endfunction

        function longint coef(int r, int c);
            logic [CFG_W-1:0] rv;
            rv = mat_regs[r * 2 + c / 2];
            return (c % 2) ? longint'($signed(rv[63:32])) : longint'($signed(rv[31:0]));
        endfunction

        function logic [31:0] clamp_word(longint v, inout logic sat);
            if (v > 64'sd2147483647)
            begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            if (v < -64'sd2147483648)
            begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return v[31:0];
        endfunction

        // num * 2^16 / den, truncated toward zero, sign applied after clamping
        function logic [31:0] quotient(longint num, longint den, logic neg, inout logic sat);
            logic [99:0] n;
            logic [99:0] d;
            logic [99:0] q;
            logic [32:0] mag;
            n = (num < 0) ? 100'(-num) : 100'(num);
            d = (den < 0) ? 100'(-den) : 100'(den);
            q = (n << 16) / d;
            mag = (q >= 100'h1_0000_0000) ? 33'h1_0000_0000 : q[32:0];
            if (neg)
            begin
                if (mag > 33'h8000_0000)
                begin
                    sat = 1'b1;
                    mag = 33'h8000_0000;
                end
                return 32'(33'h1_0000_0000 - mag);
            end
            if (mag > 33'h7FFF_FFFF)
            begin
                sat = 1'b1;
                mag = 33'h7FFF_FFFF;
            end
            return mag[31:0];
        endfunction

        function void note(logic [1:0] func, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
            logic signed [65:0] acc;
            logic signed [65:0] pt [3];
            longint             s [4];
            logic [31:0]        res [3];
            vertex_t            e;
            logic               sat;
            logic               neg;
            pt[0] = $signed(px);
            pt[1] = $signed(py);
            pt[2] = $signed(pz);
            // exact row sums, floored to Q16.16, plus translation
            for (int r = 0; r < 4; r++)
            begin
                acc = 0;
                for (int c = 0; c < 3; c++)
                    acc = acc + 66'(coef(r, c)) * pt[c];
                acc = acc >>> 16;
                s[r] = longint'(acc) + coef(r, 3);
            end
            sat = 1'b0;
            e = '0;
            e.w = clamp_word(s[3], sat);
            if (func == FUNC_DIV_W || func == FUNC_DIV_ABS)
            begin
                if (s[3] == 0)
                begin
                    e.zero_w = 1'b1;
                    e.w = '0;
                    res[0] = '0;
                    res[1] = '0;
                    res[2] = '0;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg = (s[i] < 0) ^ (func == FUNC_DIV_W && s[3] < 0);
                        res[i] = quotient(s[i], s[3], neg, sat);
                    end
                end
            end
            else
            begin
                // no divide, spare code included
                for (int i = 0; i < 3; i++)
                    res[i] = clamp_word(s[i], sat);
            end
            e.x = res[0];
            e.y = res[1];
            e.z = res[2];
            e.sat = sat;
            pending.push_back(e);
            noted++;
        endfunction

        // returns the names of wrong fields, empty when all match
        function string check(vertex_t got);
            vertex_t e;
            string   bad;
            if (pending.size() == 0)
                return "unexpected result";
            e = pending.pop_front();
            checked++;
            bad = "";
            if (got.x !== e.x)
                bad = {bad, $sformatf(" out_x %h/%h", got.x, e.x)};
            if (got.y !== e.y)
                bad = {bad, $sformatf(" out_y %h/%h", got.y, e.y)};
            if (got.z !== e.z)
                bad = {bad, $sformatf(" out_z %h/%h", got.z, e.z)};
            if (got.w !== e.w)
                bad = {bad, $sformatf(" out_w %h/%h", got.w, e.w)};
            if (got.zero_w !== e.zero_w)
                bad = {bad, $sformatf(" zero_w %b/%b", got.zero_w, e.zero_w)};
            if (got.sat !== e.sat)
                bad = {bad, $sformatf(" saturated %b/%b", got.sat, e.sat)};
            return bad;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [95:0]        s_tdata;
    logic [1:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [127:0]       m_tdata;
    logic [1:0]         m_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    vertex_scoreboard   board;
    int                 mismatches;
    int                 idle_cycles;
    int                 zero_w_seen;
    int                 sat_seen;
    int                 phases_run;
    bit                 calm;

    homogeneous_vertex_transform_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(string msg);
        mismatches++;
        $display("mismatch at %0t:%s", $realtime, msg);
    endtask

    // Result side: random stall bursts until the calm part
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Sample handshakes mid-cycle; they complete at the next rising edge
    always @(negedge clk)
    begin
        string   bad;
        vertex_t got;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
                       m_tuser[0], m_tuser[1]};
                zero_w_seen += got.zero_w;
                sat_seen += got.sat;
                bad = board.check(got);
                if (bad != "")
                    report(bad);
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_vertex(logic [1:0] func, logic [31:0] px, logic [31:0] py,
                               logic [31:0] pz);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {pz, py, px};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        board.note(func, px, py, pz);
    endtask

    // Back-to-back writes keep cfg_valid high; the caller drops it after the last one
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        if (idx < NUM_REGS)
            board.mat_regs[idx] = val;
    endtask

    // Hold the sender until every expected vertex is back and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word(int kind);
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3, 4: return $urandom();
            default: return (kind == 0) ? 32'($signed($urandom_range(0, 32'h00FF_FFFF)) -
                                               32'sh0080_0000)
                                        : 32'($signed($urandom_range(0, 32'h0003_FFFF)) -
                                               32'sh0002_0000);
        endcase
    endfunction

    // Matrix setting per phase: random, perspective, zero w row, extremes
    task automatic load_matrix(int kind);
        logic [CFG_W-1:0] v [NUM_REGS];
        for (int i = 0; i < NUM_REGS; i++)
            v[i] = {rand_word(1), rand_word(1)};
        case (kind)
            1:
            begin
                // w follows z, so z of zero gives a zero w
                v[6] = v[4];
                v[7] = {32'h0, v[5][31:0]};
                v[5][63:32] = 32'h0;
            end
            2:
            begin
                v[6] = '0;
                v[7] = '0;
            end
            3:
                for (int i = 0; i < NUM_REGS; i++)
                    v[i] = {$urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                            $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000};
            default: ;
        endcase
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(IDX_W'(i), v[i]);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] ext [4];
        board = new();
        board.load_reset();
        mismatches = 0;
        idle_cycles = 0;
        calm = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme coordinates in every mode under the reset identity
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000};
        for (int f = 0; f < 4; f++)
            for (int i = 0; i < 4; i++)
                send_vertex(2'(f), ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
        drain();
        // perspective matrix with w taken from y: positive and negative w, all four modes
        write_reg(4'd6, {32'h0001_0000, 32'h0});
        write_reg(4'd7, '0);
        write_reg(4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_valid <= 1'b0;
        send_vertex(FUNC_DIV_W, 32'h0002_0000, 32'h0003_0000, 32'h0);
        send_vertex(FUNC_DIV_ABS, 32'h0002_0000, 32'h0003_0000, 32'h0);
        send_vertex(FUNC_DIV_W, 32'h0002_0000, 32'hFFFD_0000, 32'hFFFF_0000);
        send_vertex(FUNC_DIV_ABS, 32'h0002_0000, 32'hFFFD_0000, 32'hFFFF_0000);
        send_vertex(FUNC_DIV_W, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_vertex(FUNC_DIV_ABS, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_vertex(FUNC_NO_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_vertex(FUNC_RESERVED, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);

        // Random phases, each with a fresh matrix; the last runs without idling
        for (int p = 0; p < 12; p++)
        begin
            drain();
            load_matrix(p % 5);
            phases_run++;
            calm = (p == 11);
            for (int n = 0; n < 155; n++)
                send_vertex(2'($urandom_range(0, 3)), rand_word(0), rand_word(0),
                            ($urandom_range(0, 9) == 0) ? 32'h0 : rand_word(0));
        end
        drain();

        $display("%0d vertices checked over %0d matrix settings", board.checked, phases_run + 2);
        $display("%0d with zero w, %0d saturated", zero_w_seen, sat_seen);
        if (mismatches == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
        begin
            if (board.pending.size() != 0)
                report($sformatf(" %0d expected vertices never came", board.pending.size()));
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
